// File: src/midi_track_truncation_scanner_top_assert.svh
// ----------------------------------------------------------------------------
// midi_track_truncation_scanner_top_assert.svh
// Assertion macros for the track truncation scanner.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_TRUNCATION_SCANNER_TOP_ASSERT_SVH
`define MIDI_TRACK_TRUNCATION_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define MTTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while in reset.
`define MTTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mtts_pkg.sv
// ----------------------------------------------------------------------------
// mtts_pkg
// Shared constants and types of the track truncation scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mtts_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int CFG_INDEX_BITS = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYTES_AVAILABLE  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RECOVERY_ENABLED = 1'd1;

    // Event codes
    localparam logic [7:0] EVT_META          = 8'hFF;
    localparam logic [7:0] EVT_SYSEX         = 8'hF0;
    localparam logic [3:0] MSG_SYSTEM        = 4'hF;
    localparam logic [3:0] MSG_PROGRAM       = 4'hC;
    localparam logic [3:0] MSG_CHAN_PRESSURE = 4'hD;
    localparam logic [3:0] RS_NONE           = 4'h0;

    // Length of the appended end-of-track event
    localparam logic [VALUE_BITS-1:0] EOT_BYTES = 32'd4;

    // Beyond this a further length digit overflows 32 bits
    localparam logic [VALUE_BITS-1:0] LEN_SAT_LIMIT = 32'h01FF_FFFF;

    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] cut_offset;
        logic [VALUE_BITS-1:0] new_length;
        logic                  status;
    } mtts_result_t;

endpackage

`default_nettype wire

// File: src/mtts_scan.sv
// ----------------------------------------------------------------------------
// mtts_scan
// Event walker: scan state plus the per-beat next-state and stop logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mtts_scan
    import mtts_pkg::*;
#(
    parameter int OFFSET_BITS     = 32,
    parameter int MAX_DELTA_EXTRA = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  first,
    input  wire logic [VALUE_BITS-1:0] bytes_available,
    input  wire logic                  recovery_enabled,
    output      mtts_result_t          result
);

    localparam int PREFIX_BITS = $clog2(MAX_DELTA_EXTRA + 1);
    localparam int WIDE_BITS   = VALUE_BITS + 2;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_METATYPE,
        PH_LEN,
        PH_SKIP
    } phase_t;

    phase_t                  phase_reg,          phase_next;
    logic [OFFSET_BITS-1:0]  position_reg,       position_next;
    logic [VALUE_BITS-1:0]   event_start_reg,    event_start_next;
    logic [3:0]              running_status_reg, running_status_next;
    logic [VALUE_BITS-1:0]   length_value_reg,   length_value_next;
    logic [PREFIX_BITS-1:0]  prefix_count_reg,   prefix_count_next;
    logic [VALUE_BITS-1:0]   skip_remaining_reg, skip_remaining_next;
    logic                    finished_reg,       finished_next;

    always_comb
    begin
        logic [WIDE_BITS-1:0]  a_w;
        logic [WIDE_BITS-1:0]  p_w;
        logic [WIDE_BITS-1:0]  end_w;
        logic [VALUE_BITS-1:0] lv;
        logic [VALUE_BITS-1:0] cut;
        logic [1:0]            n;
        logic                  emit;
        logic                  refuse;

        // restart clears the scan before this byte is looked at
        phase_next          = first ? PH_DELTA : phase_reg;
        position_next       = first ? '0 : position_reg;
        event_start_next    = first ? '0 : event_start_reg;
        running_status_next = first ? RS_NONE : running_status_reg;
        length_value_next   = first ? '0 : length_value_reg;
        prefix_count_next   = first ? '0 : prefix_count_reg;
        skip_remaining_next = first ? '0 : skip_remaining_reg;
        finished_next       = first ? 1'b0 : finished_reg;

        a_w    = {2'b00, bytes_available};
        p_w    = WIDE_BITS'(position_next);
        end_w  = '0;
        lv     = '0;
        cut    = event_start_next;
        n      = 2'd2;
        emit   = 1'b0;
        refuse = 1'b0;

        if (!finished_next)
        begin
            if (position_next != '1)
            begin
                position_next = position_next + 1'b1;
            end

            if (p_w == '0 && phase_next == PH_DELTA && prefix_count_next == '0)
            begin
                if (!recovery_enabled)
                begin
                    refuse = 1'b1;
                end
                else if (bytes_available < EOT_BYTES)
                begin
                    emit = 1'b1;
                    cut  = '0;
                end
            end

            if (!refuse && !emit)
            begin
                case (phase_next)
                    PH_DELTA:
                    begin
                        if (data_byte[7] && prefix_count_next < PREFIX_BITS'(MAX_DELTA_EXTRA))
                        begin
                            prefix_count_next = prefix_count_next + 1'b1;
                            emit = (a_w < p_w + WIDE_BITS'(5));
                        end
                        else
                        begin
                            prefix_count_next = '0;
                            emit = (a_w < p_w + WIDE_BITS'(4));
                            phase_next = PH_STATUS;
                        end
                    end
                    PH_STATUS:
                    begin
                        if (data_byte == EVT_META)
                        begin
                            emit = (a_w < p_w + WIDE_BITS'(6));
                            phase_next = PH_METATYPE;
                        end
                        else if (data_byte == EVT_SYSEX)
                        begin
                            emit = (a_w < p_w + WIDE_BITS'(5));
                            length_value_next = '0;
                            phase_next = PH_LEN;
                        end
                        else if (data_byte[7] && data_byte[7:4] == MSG_SYSTEM)
                        begin
                            emit = 1'b1;
                        end
                        else if (!data_byte[7] && running_status_next == RS_NONE)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            if (data_byte[7])
                            begin
                                running_status_next = data_byte[7:4];
                            end
                            n = (running_status_next == MSG_PROGRAM ||
                                 running_status_next == MSG_CHAN_PRESSURE) ? 2'd1 : 2'd2;
                            if (data_byte[7])
                            begin
                                // status byte, then n data bytes
                                end_w = p_w + WIDE_BITS'(n) + WIDE_BITS'(1);
                                skip_remaining_next = VALUE_BITS'(n);
                            end
                            else
                            begin
                                // running status: this byte is the first data byte
                                end_w = p_w + WIDE_BITS'(n);
                                skip_remaining_next = VALUE_BITS'(n - 2'd1);
                            end
                            if (a_w < end_w + WIDE_BITS'(4))
                            begin
                                emit = 1'b1;
                                cut  = end_w[VALUE_BITS-1:0];
                            end
                            event_start_next = end_w[VALUE_BITS-1:0];
                            phase_next = (skip_remaining_next == '0) ? PH_DELTA : PH_SKIP;
                        end
                    end
                    PH_METATYPE:
                    begin
                        length_value_next = '0;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (length_value_next > LEN_SAT_LIMIT)
                        begin
                            lv = '1;
                        end
                        else
                        begin
                            lv = {length_value_next[VALUE_BITS-8:0], data_byte[6:0]};
                        end
                        length_value_next = lv;
                        end_w = p_w + WIDE_BITS'(1) + WIDE_BITS'(lv);
                        if (data_byte[7])
                        begin
                            // unterminated at the last buffer byte
                            emit = (p_w + WIDE_BITS'(1) >= a_w);
                        end
                        else if (end_w > a_w)
                        begin
                            emit = 1'b1;
                        end
                        else if (a_w < end_w + WIDE_BITS'(4))
                        begin
                            emit = 1'b1;
                            cut  = end_w[VALUE_BITS-1:0];
                        end
                        else
                        begin
                            event_start_next    = end_w[VALUE_BITS-1:0];
                            skip_remaining_next = lv;
                            phase_next = (lv == '0) ? PH_DELTA : PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (skip_remaining_next != '0)
                        begin
                            skip_remaining_next = skip_remaining_next - 1'b1;
                        end
                        if (skip_remaining_next == '0)
                        begin
                            phase_next = PH_DELTA;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DELTA;
                    end
                endcase
            end
        end

        finished_next = finished_next | emit | refuse;

        result.valid      = emit | refuse;
        result.cut_offset = refuse ? '0 : cut;
        result.new_length = refuse ? '0 : cut + EOT_BYTES;
        result.status     = refuse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_DELTA;
            position_reg       <= '0;
            event_start_reg    <= '0;
            running_status_reg <= RS_NONE;
            length_value_reg   <= '0;
            prefix_count_reg   <= '0;
            skip_remaining_reg <= '0;
            finished_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            position_reg       <= position_next;
            event_start_reg    <= event_start_next;
            running_status_reg <= running_status_next;
            length_value_reg   <= length_value_next;
            prefix_count_reg   <= prefix_count_next;
            skip_remaining_reg <= skip_remaining_next;
            finished_reg       <= finished_next;
        end
    end

endmodule

`default_nettype wire

// File: src/midi_track_truncation_scanner_top.sv
// ----------------------------------------------------------------------------
// midi_track_truncation_scanner_top
// Finds where a damaged MIDI track must be cut and its repaired length.
// ----------------------------------------------------------------------------
// Track bytes stream in on s_* one per beat; s_tuser high marks the first
// byte of a track and restarts the scan. The block walks delta-times, meta,
// sysex and channel events (running status included) and, at the first event
// that is incomplete, illegal or does not fit in bytes_available, returns a
// single beat on m_*: the offset where that event starts and that offset
// plus four, room for an appended end-of-track. m_tuser high means recovery
// was disabled and nothing was cut. Bytes after the result are dropped until
// the next first byte. Throughput is one byte per clock while the sink takes
// results; a result held on m_* stalls intake. The byte that decides a result
// passes the input register, then the scan logic, into the result register.
// Configuration writes (index 0 bytes_available, index 1 recovery_enabled)
// take effect at once and belong between tracks, while the block is idle.
// There is no memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_track_truncation_scanner_top_assert.svh"

module midi_track_truncation_scanner_top
    import mtts_pkg::*;
#(
    parameter int OFFSET_BITS     = 32,   // position counter width, 16 to 32
    parameter int MAX_DELTA_EXTRA = 4     // continuation bytes allowed in a delta-time
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // byte stream in
    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    input  wire logic [7:0]                s_tdata,    // [7:0] data_byte
    input  wire logic                      s_tuser,    // [0] first

    // result out
    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    output      logic [2*VALUE_BITS-1:0]   m_tdata,    // [31:0] cut_offset, [63:32] new_length
    output      logic                      m_tuser,    // [0] status

    // configuration
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [VALUE_BITS-1:0]     cfg_wdata
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_first_reg;
    logic                  proc_en;

    logic [VALUE_BITS-1:0] bytes_available_reg;
    logic                  recovery_enabled_reg;

    mtts_result_t          scan_result;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_cut_reg;
    logic [VALUE_BITS-1:0] out_len_reg;
    logic                  out_status_reg;

    // A byte in the input register is scanned when the result register is
    // free or drains this cycle; a result held by the sink keeps the byte
    // in place and stalls intake.
    assign proc_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;

    // --- configuration registers ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_available_reg  <= '0;
            recovery_enabled_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BYTES_AVAILABLE:  bytes_available_reg  <= cfg_wdata;
                REG_RECOVERY_ENABLED: recovery_enabled_reg <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    // --- input register ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    // --- event walker ---
    mtts_scan #(
        .OFFSET_BITS     (OFFSET_BITS),
        .MAX_DELTA_EXTRA (MAX_DELTA_EXTRA)
    ) u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (proc_en),
        .data_byte        (in_byte_reg),
        .first            (in_first_reg),
        .bytes_available  (bytes_available_reg),
        .recovery_enabled (recovery_enabled_reg),
        .result           (scan_result)
    );

    // --- result register ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_en && scan_result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && scan_result.valid)
        begin
            out_cut_reg    <= scan_result.cut_offset;
            out_len_reg    <= scan_result.new_length;
            out_status_reg <= scan_result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_cut_reg};
    assign m_tuser  = out_status_reg;

    // --- assertions ---
    // a refusal carries an all-zero payload
    `MTTS_ASSERT_NOW(a_refusal_zero, out_valid_reg && out_status_reg,
        out_cut_reg == '0 && out_len_reg == '0, "refusal with nonzero offset or length")
    // a recovered cut always leaves room for the end-of-track event
    `MTTS_ASSERT_NOW(a_len_is_cut_plus_eot, out_valid_reg && !out_status_reg,
        out_len_reg == out_cut_reg + EOT_BYTES, "new length is not cut offset plus four")
    // a byte held back by a full result register is kept, not lost
    `MTTS_ASSERT_NEXT(a_held_byte_kept, in_valid_reg && !proc_en,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_first_reg),
        "stalled input byte lost or changed")

endmodule

`default_nettype wire
